### src/xml_entity_decoder_unit_assert.svh
// Assertion macros shared by the XML entity decoder RTL.
// Define NO_ASSERTIONS to compile every check away; no other dependencies.
`ifndef XML_ENTITY_DECODER_UNIT_ASSERT_SVH
`define XML_ENTITY_DECODER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked at each rising clock edge out of reset.
`define XED_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked at each rising clock edge out of reset.
`define XED_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define XED_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define XED_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

### src/xed_pkg.sv
// Package of the XML entity decoder: word types, decoder state, character
// constants and the constant marker and entity-name tables. No dependencies.
package xed_pkg;

    // Input and result words.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        done_res;
        logic        error;
        logic [15:0] decoded_count;
    } t_out_word;

    // Decoder modes, one-hot.
    typedef enum logic [10:0] {
        MODE_PLAIN = 11'b000_0000_0001,
        MODE_OPEN  = 11'b000_0000_0010,
        MODE_CDATA = 11'b000_0000_0100,
        MODE_AMP   = 11'b000_0000_1000,
        MODE_A     = 11'b000_0001_0000,
        MODE_NAME  = 11'b000_0010_0000,
        MODE_HASH  = 11'b000_0100_0000,
        MODE_DEC   = 11'b000_1000_0000,
        MODE_HEX0  = 11'b001_0000_0000,
        MODE_HEX   = 11'b010_0000_0000,
        MODE_ERR   = 11'b100_0000_0000
    } t_mode;

    // Kind of a run of held marker bytes.
    typedef enum logic {
        SEG_OPENER  = 1'b0,
        SEG_BRACKET = 1'b1
    } t_seg_kind;

    // Decoder state carried from one word to the next.
    typedef struct packed {
        t_mode      mode;
        logic [3:0] progress;
        logic [2:0] name_idx;
        logic [7:0] num_value;
        logic       err_seen;
    } t_dec_state;

    // Result bytes of one input word: a held run, one byte, a flushed run.
    typedef struct packed {
        t_seg_kind  kind_a;
        logic [3:0] len_a;
        logic       has_v;
        logic [7:0] v_byte;
        t_seg_kind  kind_b;
        logic [3:0] len_b;
        logic       err_flag;
        logic       last;
    } t_emit_plan;

    localparam t_dec_state DEC_STATE_RESET = '{
        mode:      MODE_PLAIN,
        progress:  4'd0,
        name_idx:  3'd0,
        num_value: 8'd0,
        err_seen:  1'b0
    };

    // Entity name indexes.
    localparam logic [2:0] NAME_AMP  = 3'd0;
    localparam logic [2:0] NAME_APOS = 3'd1;
    localparam logic [2:0] NAME_GT   = 3'd2;
    localparam logic [2:0] NAME_LT   = 3'd3;
    localparam logic [2:0] NAME_QUOT = 3'd4;

    localparam logic [3:0] OPENER_LEN = 4'd9;
    localparam logic [3:0] NAME_SPAN  = 4'd6;
    localparam logic [3:0] BRACKET_MAX = 4'd2;

    localparam logic [15:0] COUNT_OUT_MAX = 16'hFFFF;
    localparam logic [15:0] LIMIT_RESET   = 16'hFFFF;

    // Characters.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_APOS  = 8'h27;
    localparam logic [7:0] CH_QUOT  = 8'h22;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_RBRK  = 8'h5D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UC    = 8'h43;
    localparam logic [7:0] CH_UD    = 8'h44;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_UT    = 8'h54;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_LG    = 8'h67;
    localparam logic [7:0] CH_LL    = 8'h6C;
    localparam logic [7:0] CH_LM    = 8'h6D;
    localparam logic [7:0] CH_LO    = 8'h6F;
    localparam logic [7:0] CH_LP    = 8'h70;
    localparam logic [7:0] CH_LQ    = 8'h71;
    localparam logic [7:0] CH_LS    = 8'h73;
    localparam logic [7:0] CH_LT_T  = 8'h74;
    localparam logic [7:0] CH_LU    = 8'h75;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] HEX_UPPER_BIAS = 8'h37;
    localparam logic [7:0] HEX_LOWER_BIAS = 8'h57;

    // Byte at a position of the CDATA opener "<![CDATA[".
    function automatic logic [7:0] opener_char(input logic [3:0] pos);
        logic [7:0] ch;
        case (pos)
            4'd0:    ch = CH_LT;
            4'd1:    ch = CH_BANG;
            4'd2:    ch = CH_LBRK;
            4'd3:    ch = CH_UC;
            4'd4:    ch = CH_UD;
            4'd5:    ch = CH_UA;
            4'd6:    ch = CH_UT;
            4'd7:    ch = CH_UA;
            4'd8:    ch = CH_LBRK;
            default: ch = CH_NUL;
        endcase
        return ch;
    endfunction

    // Byte at a position of an entity name, terminator included; NUL past it.
    function automatic logic [7:0] name_char(input logic [2:0] idx, input logic [3:0] pos);
        logic [7:0] ch;
        ch = CH_NUL;
        case (idx)
            NAME_AMP: begin
                case (pos)
                    4'd0:    ch = CH_LA;
                    4'd1:    ch = CH_LM;
                    4'd2:    ch = CH_LP;
                    4'd3:    ch = CH_SEMI;
                    default: ch = CH_NUL;
                endcase
            end
            NAME_APOS: begin
                case (pos)
                    4'd0:    ch = CH_LA;
                    4'd1:    ch = CH_LP;
                    4'd2:    ch = CH_LO;
                    4'd3:    ch = CH_LS;
                    4'd4:    ch = CH_SEMI;
                    default: ch = CH_NUL;
                endcase
            end
            NAME_GT: begin
                case (pos)
                    4'd0:    ch = CH_LG;
                    4'd1:    ch = CH_LT_T;
                    4'd2:    ch = CH_SEMI;
                    default: ch = CH_NUL;
                endcase
            end
            NAME_LT: begin
                case (pos)
                    4'd0:    ch = CH_LL;
                    4'd1:    ch = CH_LT_T;
                    4'd2:    ch = CH_SEMI;
                    default: ch = CH_NUL;
                endcase
            end
            NAME_QUOT: begin
                case (pos)
                    4'd0:    ch = CH_LQ;
                    4'd1:    ch = CH_LU;
                    4'd2:    ch = CH_LO;
                    4'd3:    ch = CH_LT_T;
                    4'd4:    ch = CH_SEMI;
                    default: ch = CH_NUL;
                endcase
            end
            default: ch = CH_NUL;
        endcase
        return ch;
    endfunction

    // Decoded byte of a named entity.
    function automatic logic [7:0] name_value(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            NAME_AMP:  ch = CH_AMP;
            NAME_APOS: ch = CH_APOS;
            NAME_GT:   ch = CH_GT;
            NAME_LT:   ch = CH_LT;
            NAME_QUOT: ch = CH_QUOT;
            default:   ch = CH_NUL;
        endcase
        return ch;
    endfunction

    // Hex digit value; the top bit tells whether the byte is a hex digit.
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= CH_0 && b <= CH_9) begin
            r = {1'b1, 4'(b - CH_0)};
        end else if (b >= CH_UA && b <= CH_UF) begin
            r = {1'b1, 4'(b - HEX_UPPER_BIAS)};
        end else if (b >= CH_LA && b <= CH_LF) begin
            r = {1'b1, 4'(b - HEX_LOWER_BIAS)};
        end
        return r;
    endfunction

endpackage

### src/xed_step.sv
// Decode step of the XML entity decoder: next state and result plan for one
// input word. Purely combinational; depends on xed_pkg.
module xed_step (
    input  xed_pkg::t_dec_state i_state,
    input  xed_pkg::t_in_word   i_word,
    output xed_pkg::t_dec_state o_next,
    output xed_pkg::t_emit_plan o_plan
);

    logic [7:0] w_b;
    logic       w_is_dig;
    logic [7:0] w_dig;
    logic [4:0] w_hex;
    logic [7:0] w_name_ch;
    logic       w_name_hit;
    logic       w_open_hit;

    // Plain-text handling of the current byte, shared by two modes.
    xed_pkg::t_mode w_pl_mode;
    logic [3:0]     w_pl_prog;
    logic           w_pl_has_v;

    xed_pkg::t_dec_state n_state;
    xed_pkg::t_emit_plan w_plan;

    assign w_b        = i_word.in_byte;
    assign w_is_dig   = (w_b >= xed_pkg::CH_0) && (w_b <= xed_pkg::CH_9);
    assign w_dig      = w_b - xed_pkg::CH_0;
    assign w_hex      = xed_pkg::hex_value(w_b);
    assign w_name_ch  = xed_pkg::name_char(i_state.name_idx, i_state.progress);
    assign w_name_hit = (i_state.progress < xed_pkg::NAME_SPAN) &&
                        (w_b != xed_pkg::CH_NUL) && (w_b == w_name_ch);
    assign w_open_hit = (i_state.progress < xed_pkg::OPENER_LEN) &&
                        (w_b == xed_pkg::opener_char(i_state.progress));

    // A byte in plain text opens a marker, opens an entity or is text.
    always_comb begin
        w_pl_mode  = xed_pkg::MODE_PLAIN;
        w_pl_prog  = 4'd0;
        w_pl_has_v = 1'b0;
        if (w_b == xed_pkg::CH_LT) begin
            w_pl_mode = xed_pkg::MODE_OPEN;
            w_pl_prog = 4'd1;
        end else if (w_b == xed_pkg::CH_AMP) begin
            w_pl_mode = xed_pkg::MODE_AMP;
        end else begin
            w_pl_has_v = 1'b1;
        end
    end

    // Mode transitions and the bytes this word releases.
    always_comb begin
        n_state        = i_state;
        w_plan.kind_a  = xed_pkg::SEG_OPENER;
        w_plan.len_a   = 4'd0;
        w_plan.has_v   = 1'b0;
        w_plan.v_byte  = w_b;
        w_plan.kind_b  = xed_pkg::SEG_OPENER;
        w_plan.len_b   = 4'd0;
        w_plan.err_flag = 1'b0;
        w_plan.last    = i_word.last_byte;

        case (i_state.mode)
            xed_pkg::MODE_PLAIN: begin
                n_state.mode     = w_pl_mode;
                n_state.progress = w_pl_prog;
                w_plan.has_v     = w_pl_has_v;
            end
            xed_pkg::MODE_OPEN: begin
                if (w_open_hit) begin
                    if (i_state.progress + 4'd1 >= xed_pkg::OPENER_LEN) begin
                        n_state.mode     = xed_pkg::MODE_CDATA;
                        n_state.progress = 4'd0;
                    end else begin
                        n_state.progress = i_state.progress + 4'd1;
                    end
                end else begin
                    // Release the held opener bytes, then treat the byte as text.
                    w_plan.kind_a    = xed_pkg::SEG_OPENER;
                    w_plan.len_a     = i_state.progress;
                    n_state.mode     = w_pl_mode;
                    n_state.progress = w_pl_prog;
                    w_plan.has_v     = w_pl_has_v;
                end
            end
            xed_pkg::MODE_CDATA: begin
                if (w_b == xed_pkg::CH_RBRK) begin
                    if (i_state.progress < xed_pkg::BRACKET_MAX) begin
                        n_state.progress = i_state.progress + 4'd1;
                    end else begin
                        w_plan.has_v = 1'b1;
                    end
                end else if (w_b == xed_pkg::CH_GT &&
                             i_state.progress >= xed_pkg::BRACKET_MAX) begin
                    n_state.mode     = xed_pkg::MODE_PLAIN;
                    n_state.progress = 4'd0;
                end else begin
                    // Held brackets were section text after all.
                    w_plan.kind_a    = xed_pkg::SEG_BRACKET;
                    w_plan.len_a     = i_state.progress;
                    w_plan.has_v     = 1'b1;
                    n_state.progress = 4'd0;
                end
            end
            xed_pkg::MODE_AMP: begin
                n_state.mode = xed_pkg::MODE_NAME;
                n_state.progress = 4'd1;
                if (w_b == xed_pkg::CH_LA) begin
                    n_state.mode     = xed_pkg::MODE_A;
                    n_state.progress = 4'd0;
                end else if (w_b == xed_pkg::CH_LG) begin
                    n_state.name_idx = xed_pkg::NAME_GT;
                end else if (w_b == xed_pkg::CH_LL) begin
                    n_state.name_idx = xed_pkg::NAME_LT;
                end else if (w_b == xed_pkg::CH_LQ) begin
                    n_state.name_idx = xed_pkg::NAME_QUOT;
                end else if (w_b == xed_pkg::CH_HASH) begin
                    n_state.mode     = xed_pkg::MODE_HASH;
                    n_state.progress = 4'd0;
                end else begin
                    n_state.mode      = xed_pkg::MODE_ERR;
                    n_state.progress  = 4'd0;
                    n_state.num_value = 8'd0;
                    n_state.err_seen  = 1'b1;
                end
            end
            xed_pkg::MODE_A: begin
                n_state.mode     = xed_pkg::MODE_NAME;
                n_state.progress = 4'd2;
                if (w_b == xed_pkg::CH_LM) begin
                    n_state.name_idx = xed_pkg::NAME_AMP;
                end else if (w_b == xed_pkg::CH_LP) begin
                    n_state.name_idx = xed_pkg::NAME_APOS;
                end else begin
                    n_state.mode      = xed_pkg::MODE_ERR;
                    n_state.progress  = 4'd0;
                    n_state.num_value = 8'd0;
                    n_state.err_seen  = 1'b1;
                end
            end
            xed_pkg::MODE_NAME: begin
                if (w_name_hit && w_b == xed_pkg::CH_SEMI) begin
                    w_plan.has_v      = 1'b1;
                    w_plan.v_byte     = xed_pkg::name_value(i_state.name_idx);
                    n_state.mode      = xed_pkg::MODE_PLAIN;
                    n_state.progress  = 4'd0;
                    n_state.num_value = 8'd0;
                end else if (w_name_hit) begin
                    n_state.progress = i_state.progress + 4'd1;
                end else begin
                    n_state.mode      = xed_pkg::MODE_ERR;
                    n_state.progress  = 4'd0;
                    n_state.num_value = 8'd0;
                    n_state.err_seen  = 1'b1;
                end
            end
            xed_pkg::MODE_HASH: begin
                if (w_is_dig) begin
                    n_state.num_value = w_dig;
                    n_state.mode      = xed_pkg::MODE_DEC;
                end else if (w_b == xed_pkg::CH_LX) begin
                    n_state.mode = xed_pkg::MODE_HEX0;
                end else begin
                    n_state.mode      = xed_pkg::MODE_ERR;
                    n_state.progress  = 4'd0;
                    n_state.num_value = 8'd0;
                    n_state.err_seen  = 1'b1;
                end
            end
            xed_pkg::MODE_DEC: begin
                if (w_is_dig) begin
                    // Times ten as two shifts, kept modulo 256.
                    n_state.num_value = {i_state.num_value[4:0], 3'b000} +
                                        {i_state.num_value[6:0], 1'b0} + w_dig;
                end else if (w_b == xed_pkg::CH_SEMI) begin
                    w_plan.has_v      = 1'b1;
                    w_plan.v_byte     = i_state.num_value;
                    n_state.mode      = xed_pkg::MODE_PLAIN;
                    n_state.progress  = 4'd0;
                    n_state.num_value = 8'd0;
                end else begin
                    n_state.mode      = xed_pkg::MODE_ERR;
                    n_state.progress  = 4'd0;
                    n_state.num_value = 8'd0;
                    n_state.err_seen  = 1'b1;
                end
            end
            xed_pkg::MODE_HEX0: begin
                if (w_hex[4]) begin
                    n_state.num_value = {4'd0, w_hex[3:0]};
                    n_state.mode      = xed_pkg::MODE_HEX;
                end else begin
                    n_state.mode      = xed_pkg::MODE_ERR;
                    n_state.progress  = 4'd0;
                    n_state.num_value = 8'd0;
                    n_state.err_seen  = 1'b1;
                end
            end
            xed_pkg::MODE_HEX: begin
                if (w_hex[4]) begin
                    n_state.num_value = {i_state.num_value[3:0], w_hex[3:0]};
                end else if (w_b == xed_pkg::CH_SEMI) begin
                    w_plan.has_v      = 1'b1;
                    w_plan.v_byte     = i_state.num_value;
                    n_state.mode      = xed_pkg::MODE_PLAIN;
                    n_state.progress  = 4'd0;
                    n_state.num_value = 8'd0;
                end else begin
                    n_state.mode      = xed_pkg::MODE_ERR;
                    n_state.progress  = 4'd0;
                    n_state.num_value = 8'd0;
                    n_state.err_seen  = 1'b1;
                end
            end
            xed_pkg::MODE_ERR: begin
                n_state = i_state;
            end
            default: begin
                n_state = xed_pkg::DEC_STATE_RESET;
            end
        endcase

        // End of body: flush held marker bytes, flag an open entity.
        if (i_word.last_byte) begin
            if (n_state.mode == xed_pkg::MODE_OPEN) begin
                w_plan.kind_b = xed_pkg::SEG_OPENER;
                w_plan.len_b  = n_state.progress;
            end else if (n_state.mode == xed_pkg::MODE_CDATA) begin
                w_plan.kind_b = xed_pkg::SEG_BRACKET;
                w_plan.len_b  = n_state.progress;
            end else if (n_state.mode == xed_pkg::MODE_AMP ||
                         n_state.mode == xed_pkg::MODE_A ||
                         n_state.mode == xed_pkg::MODE_NAME ||
                         n_state.mode == xed_pkg::MODE_HASH ||
                         n_state.mode == xed_pkg::MODE_DEC ||
                         n_state.mode == xed_pkg::MODE_HEX0 ||
                         n_state.mode == xed_pkg::MODE_HEX) begin
                n_state.err_seen = 1'b1;
            end
        end
        w_plan.err_flag = n_state.err_seen;
        if (i_word.last_byte) begin
            n_state = xed_pkg::DEC_STATE_RESET;
        end
    end

    assign o_next = n_state;
    assign o_plan = w_plan;

endmodule

### src/xml_entity_decoder_unit.sv
// Top level of the XML entity decoder: input register, result sequencer,
// output register. Depends on xed_pkg, xed_step and the assertion header.

// The decoder takes body text one word per cycle while o_stall is low and
// returns one result word per decoded byte, from a single output register. A
// word that releases no byte yields nothing, except the last word of a body,
// which always yields at least the done result. A word that releases n bytes
// holds the input register until all n results are loaded (n is at most 9,
// when a failed CDATA opener is flushed); the output register takes one result
// each cycle unless i_stall holds it, so unstalled plain text streams at one
// word per cycle. Each result word passes the input, then the output register.
// Bytes past the output limit come out with byte_valid low and are still
// counted; the count is reported on the done result.
`include "xml_entity_decoder_unit_assert.svh"

module xml_entity_decoder_unit #(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  xed_pkg::t_in_word i_data,
    output logic              o_valid,
    input  logic              i_stall,
    output xed_pkg::t_out_word o_data,
    input  logic              i_cfg_wr_en,
    input  logic [15:0]       i_cfg_wr_data
);

    localparam int unsigned EXT_WIDTH = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

    xed_pkg::t_in_word   r_in;
    logic                r_in_valid;
    xed_pkg::t_dec_state r_state;
    xed_pkg::t_dec_state n_state;
    xed_pkg::t_emit_plan w_plan;
    logic [3:0]          r_idx;
    logic [COUNT_WIDTH-1:0] r_total;
    logic [15:0]         r_limit;
    xed_pkg::t_out_word  r_out;
    logic                r_out_valid;
    xed_pkg::t_out_word  n_out;

    logic [3:0]  w_nbytes;
    logic        w_empty_done;
    logic [3:0]  w_nres;
    logic        w_out_free;
    logic        w_out_load;
    logic        w_is_final;
    logic        w_is_done;
    logic        w_finish;
    logic        w_accept;
    logic [3:0]  w_off_b;
    logic [7:0]  w_sel_byte;
    logic        w_deliver;
    logic [COUNT_WIDTH-1:0] w_total_inc;
    logic [COUNT_WIDTH-1:0] w_total_after;
    logic [EXT_WIDTH-1:0]   w_total_ext;
    logic [15:0] w_count_sat;

    // Decode step for the word in the input register.
    xed_step u_step (
        .i_state (r_state),
        .i_word  (r_in),
        .o_next  (n_state),
        .o_plan  (w_plan)
    );

    // Result count of the held word and sequencing handshake.
    assign w_nbytes     = w_plan.len_a + 4'(w_plan.has_v) + w_plan.len_b;
    assign w_empty_done = w_plan.last && (w_nbytes == 4'd0);
    assign w_nres       = w_empty_done ? 4'd1 : w_nbytes;
    assign w_out_free   = !r_out_valid || !i_stall;
    assign w_out_load   = r_in_valid && (w_nres != 4'd0) && w_out_free;
    assign w_is_final   = (r_idx == w_nres - 4'd1);
    assign w_is_done    = w_plan.last && w_is_final;
    assign w_finish     = r_in_valid && ((w_nres == 4'd0) || (w_out_load && w_is_final));
    assign o_stall      = r_in_valid && !w_finish;
    assign w_accept     = i_valid && !o_stall;

    // Byte at the current result index: held run, single byte, flushed run.
    assign w_off_b = r_idx - w_plan.len_a - 4'(w_plan.has_v);
    always_comb begin
        if (r_idx < w_plan.len_a) begin
            w_sel_byte = (w_plan.kind_a == xed_pkg::SEG_OPENER) ?
                         xed_pkg::opener_char(r_idx) : xed_pkg::CH_RBRK;
        end else if (w_plan.has_v && r_idx == w_plan.len_a) begin
            w_sel_byte = w_plan.v_byte;
        end else begin
            w_sel_byte = (w_plan.kind_b == xed_pkg::SEG_OPENER) ?
                         xed_pkg::opener_char(w_off_b) : xed_pkg::CH_RBRK;
        end
    end

    // Output limit check and saturating byte count.
    assign w_deliver     = EXT_WIDTH'(r_total) < EXT_WIDTH'(r_limit);
    assign w_total_inc   = (r_total == {COUNT_WIDTH{1'b1}}) ? r_total :
                           r_total + COUNT_WIDTH'(1);
    assign w_total_after = w_empty_done ? r_total : w_total_inc;
    assign w_total_ext   = EXT_WIDTH'(w_total_after);
    assign w_count_sat   = (w_total_ext > EXT_WIDTH'(xed_pkg::COUNT_OUT_MAX)) ?
                           xed_pkg::COUNT_OUT_MAX : w_total_ext[15:0];

    // Result word for the current index.
    always_comb begin
        n_out.byte_valid    = !w_empty_done && w_deliver;
        n_out.out_byte      = n_out.byte_valid ? w_sel_byte : 8'd0;
        n_out.done_res      = w_is_done;
        n_out.error         = w_is_done && w_plan.err_flag;
        n_out.decoded_count = w_is_done ? w_count_sat : 16'd0;
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_idx       <= 4'd0;
            r_state     <= xed_pkg::DEC_STATE_RESET;
            r_total     <= '0;
            r_limit     <= xed_pkg::LIMIT_RESET;
        end else begin
            if (i_cfg_wr_en) begin
                r_limit <= i_cfg_wr_data;
            end
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_finish) begin
                r_in_valid <= 1'b0;
            end
            if (w_finish) begin
                r_state <= n_state;
                r_idx   <= 4'd0;
            end else if (w_out_load) begin
                r_idx <= r_idx + 4'd1;
            end
            if (w_out_load) begin
                r_total <= w_is_done ? '0 : w_total_after;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= i_data;
        end
        if (w_out_load) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // Checks on sequencing and result fields.
    `XED_ASSERT_NOW(a_idx_needs_word, i_clk, i_rst_n, r_idx != 4'd0, r_in_valid,
        "result index advanced without a held word")
    `XED_ASSERT_NOW(a_idle_fields, i_clk, i_rst_n, o_valid && !o_data.done_res,
        !o_data.error && o_data.decoded_count == 16'd0,
        "status fields set on a result that is not the done word")
    `XED_ASSERT_NOW(a_suppressed_zero, i_clk, i_rst_n, o_valid && !o_data.byte_valid,
        o_data.out_byte == 8'd0, "suppressed result carries a nonzero byte")
    `XED_ASSERT_NEXT(a_count_cleared, i_clk, i_rst_n, w_out_load && w_is_done,
        r_total == '0 && r_state == xed_pkg::DEC_STATE_RESET,
        "body state not cleared after the done word")

endmodule
